FILE: hw/rtl/lpse_pkg.sv
// Shared types, codes and encoding functions for the LED pixel SPI pulse encoder.
// No dependencies; every other file of the block refers to this package by scoped names.
package lpse_pkg;

    // Input word: one colour component of one LED.
    typedef struct packed {
        logic [15:0] led_index;
        logic [2:0]  colour_slot;
        logic [7:0]  level;
    } t_item_in;

    // Output word: one pattern byte, or one error report.
    typedef struct packed {
        logic [15:0] byte_address;
        logic [7:0]  pattern_byte;
        logic        last;
        logic [1:0]  status;
    } t_result;

    // Live configuration registers.
    typedef struct packed {
        logic [1:0]  strip_type;
        logic [2:0]  colour_order;
        logic [2:0]  colours_per_led;
        logic [15:0] led_count;
        logic [15:0] base_offset;
    } t_cfg;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LED_OFF  = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [1:0] ST_ADDR_OVF = 2'd3;

    // Strip types. The unused code behaves as the long-high type.
    localparam logic [1:0] STRIP_THREE = 2'd0;
    localparam logic [1:0] STRIP_SHORT = 2'd1;
    localparam logic [1:0] STRIP_LONG  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STRIP_TYPE   = 3'd0;
    localparam logic [2:0] REG_COLOUR_ORDER = 3'd1;
    localparam logic [2:0] REG_COLOURS      = 3'd2;
    localparam logic [2:0] REG_LED_COUNT    = 3'd3;
    localparam logic [2:0] REG_BASE_OFFSET  = 3'd4;

    // Colour orders.
    localparam logic [2:0] ORD_GRB = 3'd0;
    localparam logic [2:0] ORD_GBR = 3'd1;
    localparam logic [2:0] ORD_RGB = 3'd2;
    localparam logic [2:0] ORD_RBG = 3'd3;
    localparam logic [2:0] ORD_BGR = 3'd4;
    localparam logic [2:0] ORD_BRG = 3'd5;

    // Stage data after the index stage.
    typedef struct packed {
        logic [15:0] led_index;
        logic [2:0]  mapped_slot;
        logic [7:0]  level;
        logic [1:0]  status;
        logic [1:0]  strip_type;
    } t_stage_idx;

    // Stage data after the multiply stage: component number within the strip.
    typedef struct packed {
        logic [18:0] component;
        logic [7:0]  level;
        logic [1:0]  status;
        logic [1:0]  strip_type;
    } t_stage_mul;

    // Stage data after the address stage.
    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  level;
        logic [1:0]  status;
        logic [1:0]  strip_type;
    } t_stage_addr;

    // Slot remap: slots R, G and B go through the order table, the rest pass.
    function automatic logic [2:0] f_map_slot(input logic [2:0] order, input logic [2:0] slot);
        logic [5:0] row;
        begin
            row = 6'b10_01_00;
            case (order)
                ORD_GRB: row = {2'd2, 2'd0, 2'd1};
                ORD_GBR: row = {2'd1, 2'd0, 2'd2};
                ORD_RGB: row = {2'd2, 2'd1, 2'd0};
                ORD_RBG: row = {2'd1, 2'd2, 2'd0};
                ORD_BGR: row = {2'd0, 2'd1, 2'd2};
                ORD_BRG: row = {2'd0, 2'd2, 2'd1};
                default: row = {2'd2, 2'd1, 2'd0};
            endcase
            case (slot)
                3'd0:    f_map_slot = {1'b0, row[1:0]};
                3'd1:    f_map_slot = {1'b0, row[3:2]};
                3'd2:    f_map_slot = {1'b0, row[5:4]};
                default: f_map_slot = slot;
            endcase
        end
    endfunction

    // Two pulse nibbles for two LED bits.
    function automatic logic [7:0] f_nibbles(input logic hi_bit, input logic lo_bit,
                                             input logic long_high);
        logic [3:0] one_nib;
        begin
            one_nib = long_high ? 4'hE : 4'hC;
            f_nibbles = {hi_bit ? one_nib : 4'h8, lo_bit ? one_nib : 4'h8};
        end
    endfunction

    // Pattern byte number idx of the encoded level.
    function automatic logic [7:0] f_pattern(input logic [7:0] v, input logic [1:0] stype,
                                             input logic [1:0] idx);
        logic long_high;
        begin
            long_high = (stype != STRIP_SHORT);
            if (stype == STRIP_THREE) begin
                case (idx)
                    2'd0:    f_pattern = 8'h92 | {1'b0, v[7], 2'b0, v[6], 2'b0, v[5]};
                    2'd1:    f_pattern = 8'h49 | {2'b0, v[4], 2'b0, v[3], 2'b0};
                    default: f_pattern = 8'h24 | {v[2], 2'b0, v[1], 2'b0, v[0], 1'b0};
                endcase
            end else begin
                case (idx)
                    2'd0:    f_pattern = f_nibbles(v[7], v[6], long_high);
                    2'd1:    f_pattern = f_nibbles(v[5], v[4], long_high);
                    2'd2:    f_pattern = f_nibbles(v[3], v[2], long_high);
                    default: f_pattern = f_nibbles(v[1], v[0], long_high);
                endcase
            end
        end
    endfunction

endpackage

FILE: hw/rtl/led_pixel_spi_pulse_encoder.sv
// Top level of the LED pixel SPI pulse encoder: configuration port, pipeline and serializer.
// Depends on lpse_pkg, lpse_cfg, lpse_index, lpse_addr and lpse_ser.

// Each accepted word (start high while busy is low) sets one colour component of one LED and
// produces a burst of output words on o_result, each marked by o_valid for exactly one cycle:
// three pattern bytes at consecutive buffer addresses for strip type 0, four for the other types,
// or a single word with a nonzero status (LED off the end, slot beyond the colour count, or an
// address that would run past 65535) and zero address and pattern. The final word of a burst has
// last set. The receiver cannot stall the block, so it must take every word in the cycle it is
// shown. A word passes four register stages (range checks and slot remap, component multiply,
// address scale and overflow check, serializer) before its results reach the output register.
// The serializer emits one byte per cycle, which sets the sustained rate: it takes the next word
// only as it emits the last pattern byte, or the single error word, of the word before. While
// the serializer is working, up to three further words queue in the stages in front of it; busy
// rises when all of them are full. The configuration registers feed the pipeline directly, so
// they should only be written while no burst is pending. pready is always high, and reads return
// the register value zero-extended.
module led_pixel_spi_pulse_encoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lpse_pkg::t_item_in     i_item,
    output logic                   o_valid,
    output lpse_pkg::t_result      o_result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    lpse_pkg::t_cfg        cfg;
    logic                  idx_ready;
    logic                  mul_valid;
    lpse_pkg::t_stage_mul  mul_data;
    logic                  addr_ready;
    logic                  addr_valid;
    lpse_pkg::t_stage_addr addr_data;
    logic                  ser_ready;

    lpse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lpse_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (start),
        .i_item  (i_item),
        .o_ready (idx_ready),
        .o_valid (mul_valid),
        .o_data  (mul_data),
        .i_ready (addr_ready)
    );

    lpse_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (mul_valid),
        .i_data  (mul_data),
        .o_ready (addr_ready),
        .o_valid (addr_valid),
        .o_data  (addr_data),
        .i_ready (ser_ready)
    );

    lpse_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (addr_valid),
        .i_data   (addr_data),
        .o_ready  (ser_ready),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // The front stage takes a word whenever it can move on or is empty.
    assign busy = !idx_ready;

    // A burst is never broken: a word without last is followed by another word.
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |=> o_valid)
        else $error("burst interrupted before its last word");

    // Bytes of one burst go to consecutive addresses.
    a_burst_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |=>
            o_result.byte_address == ($past(o_result.byte_address) + 16'd1))
        else $error("pattern bytes not at consecutive addresses");

    // An error report is a single word with zero address and pattern.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status != lpse_pkg::ST_OK |->
            o_result.last && o_result.byte_address == 16'd0 && o_result.pattern_byte == 8'd0)
        else $error("error report is not a single zero word");

    // A good burst never runs past the last buffer byte.
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last && o_result.status == lpse_pkg::ST_OK |->
            o_result.byte_address != 16'hFFFF)
        else $error("pattern burst wraps past the end of the buffer");

endmodule

FILE: hw/rtl/lpse_cfg.sv
// APB-style configuration register file of the LED pixel SPI pulse encoder.
// Depends on lpse_pkg for the configuration struct and register indexes.
module lpse_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lpse_pkg::t_cfg     o_cfg
);

    lpse_pkg::t_cfg r_cfg;
    lpse_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[4:2])
                lpse_pkg::REG_STRIP_TYPE:   n_cfg.strip_type      = pwdata[1:0];
                lpse_pkg::REG_COLOUR_ORDER: n_cfg.colour_order    = pwdata[2:0];
                lpse_pkg::REG_COLOURS:      n_cfg.colours_per_led = pwdata[2:0];
                lpse_pkg::REG_LED_COUNT:    n_cfg.led_count       = pwdata[15:0];
                lpse_pkg::REG_BASE_OFFSET:  n_cfg.base_offset     = pwdata[15:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strip_type      <= lpse_pkg::STRIP_LONG;
            r_cfg.colour_order    <= lpse_pkg::ORD_GRB;
            r_cfg.colours_per_led <= 3'd3;
            r_cfg.led_count       <= 16'd0;
            r_cfg.base_offset     <= 16'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[4:2])
            lpse_pkg::REG_STRIP_TYPE:   prdata = {30'd0, r_cfg.strip_type};
            lpse_pkg::REG_COLOUR_ORDER: prdata = {29'd0, r_cfg.colour_order};
            lpse_pkg::REG_COLOURS:      prdata = {29'd0, r_cfg.colours_per_led};
            lpse_pkg::REG_LED_COUNT:    prdata = {16'd0, r_cfg.led_count};
            lpse_pkg::REG_BASE_OFFSET:  prdata = {16'd0, r_cfg.base_offset};
            default:                    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/lpse_index.sv
// Front two pipeline stages: range checks with slot remap, then the component multiply.
// Depends on lpse_pkg for the word, configuration and stage types.
module lpse_index (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpse_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    input  lpse_pkg::t_item_in     i_item,
    output logic                   o_ready,
    output logic                   o_valid,
    output lpse_pkg::t_stage_mul   o_data,
    input  logic                   i_ready
);

    logic                 r_idx_valid;
    lpse_pkg::t_stage_idx r_idx;
    lpse_pkg::t_stage_idx n_idx;
    logic                 r_mul_valid;
    lpse_pkg::t_stage_mul r_mul;
    lpse_pkg::t_stage_mul n_mul;
    logic                 mul_ready;

    assign mul_ready = !r_mul_valid || i_ready;
    assign o_ready   = !r_idx_valid || mul_ready;

    // Checks run in priority order: LED off the end, then slot beyond the colour count.
    always_comb begin
        n_idx.led_index   = i_item.led_index;
        n_idx.mapped_slot = lpse_pkg::f_map_slot(i_cfg.colour_order, i_item.colour_slot);
        n_idx.level       = i_item.level;
        n_idx.strip_type  = i_cfg.strip_type;
        if (i_item.led_index >= i_cfg.led_count) begin
            n_idx.status = lpse_pkg::ST_LED_OFF;
        end else if (i_item.colour_slot >= i_cfg.colours_per_led) begin
            n_idx.status = lpse_pkg::ST_BAD_SLOT;
        end else begin
            n_idx.status = lpse_pkg::ST_OK;
        end
    end

    always_comb begin
        n_mul.component  = 19'(r_idx.led_index) * 19'(i_cfg.colours_per_led)
                         + 19'(r_idx.mapped_slot);
        n_mul.level      = r_idx.level;
        n_mul.status     = r_idx.status;
        n_mul.strip_type = r_idx.strip_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx_valid <= 1'b0;
            r_mul_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_idx_valid <= i_valid;
            end
            if (mul_ready) begin
                r_mul_valid <= r_idx_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_idx <= n_idx;
        end
        if (mul_ready && r_idx_valid) begin
            r_mul <= n_mul;
        end
    end

    assign o_valid = r_mul_valid;
    assign o_data  = r_mul;

endmodule

FILE: hw/rtl/lpse_addr.sv
// Address pipeline stage: scales the component number, adds the strip offset, checks overflow.
// Depends on lpse_pkg for the configuration and stage types.
module lpse_addr (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpse_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    input  lpse_pkg::t_stage_mul   i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output lpse_pkg::t_stage_addr  o_data,
    input  logic                   i_ready
);

    logic                  r_valid;
    lpse_pkg::t_stage_addr r_data;
    lpse_pkg::t_stage_addr n_data;
    logic                  three_byte;
    logic [20:0]           scaled;
    logic [21:0]           first_addr;
    logic [21:0]           end_addr;

    assign o_ready    = !r_valid || i_ready;
    assign three_byte = (i_data.strip_type == lpse_pkg::STRIP_THREE);

    always_comb begin
        scaled     = three_byte ? (21'({i_data.component, 1'b0}) + 21'(i_data.component))
                                : {i_data.component, 2'b00};
        first_addr = 22'(i_cfg.base_offset) + 22'(scaled);
        end_addr   = first_addr + (three_byte ? 22'd2 : 22'd3);
        n_data.address    = first_addr[15:0];
        n_data.level      = i_data.level;
        n_data.strip_type = i_data.strip_type;
        if (i_data.status == lpse_pkg::ST_OK && end_addr[21:16] != 6'd0) begin
            n_data.status = lpse_pkg::ST_ADDR_OVF;
        end else begin
            n_data.status = i_data.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hw/rtl/lpse_ser.sv
// Output serializer: emits one pattern byte (or one error word) per cycle into a result register.
// Depends on lpse_pkg for the stage and result types and the pattern function.
module lpse_ser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  lpse_pkg::t_stage_addr  i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output lpse_pkg::t_result      o_result
);

    logic                  r_active;
    lpse_pkg::t_stage_addr r_item;
    logic [1:0]            r_cnt;
    logic [1:0]            r_last_idx;
    logic                  r_out_valid;
    lpse_pkg::t_result     r_out;
    lpse_pkg::t_result     n_out;
    logic                  at_last;
    logic [1:0]            n_last_idx;

    assign at_last = (r_cnt == r_last_idx);
    assign o_ready = !r_active || at_last;

    always_comb begin
        if (i_data.status != lpse_pkg::ST_OK) begin
            n_last_idx = 2'd0;
        end else if (i_data.strip_type == lpse_pkg::STRIP_THREE) begin
            n_last_idx = 2'd2;
        end else begin
            n_last_idx = 2'd3;
        end
    end

    // Error words carry address and pattern zero.
    always_comb begin
        n_out.last   = at_last;
        n_out.status = r_item.status;
        if (r_item.status == lpse_pkg::ST_OK) begin
            n_out.byte_address = r_item.address + 16'(r_cnt);
            n_out.pattern_byte = lpse_pkg::f_pattern(r_item.level, r_item.strip_type, r_cnt);
        end else begin
            n_out.byte_address = 16'd0;
            n_out.pattern_byte = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_active;
            if (o_ready) begin
                r_active <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_out <= n_out;
        end
        if (o_ready) begin
            r_cnt <= 2'd0;
            if (i_valid) begin
                r_item     <= i_data;
                r_last_idx <= n_last_idx;
            end
        end else begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: test/tb_led_pixel_spi_pulse_encoder.sv
// Self-checking testbench for led_pixel_spi_pulse_encoder: directed and random color words,
// with expected pattern bytes worked out by a scoreboard class and compared word by word.
// Depends on lpse_pkg and the led_pixel_spi_pulse_encoder RTL only.
module tb_led_pixel_spi_pulse_encoder;

    // Cycles without any handshake before the run is declared hung. The slowest correct gap
    // is a random sender pause plus the settle wait.
    localparam int unsigned STALL_LIMIT   = 500;
    // Five register stages to the first result, then up to four bytes; add some margin.
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned PHASE_ITEMS   = 40;
    localparam int unsigned RANDOM_PHASES = 6;

    // Codes that the package leaves unnamed because the block treats them as fallbacks.
    localparam logic [1:0] STRIP_SPARE  = 2'd3;
    localparam logic [2:0] ORD_SPARE_LO = 3'd6;
    localparam logic [2:0] ORD_SPARE_HI = 3'd7;

    // Predicts the pattern bytes for each accepted color word and checks the output words
    // against them in order. It keeps its own copy of the register settings.
    class pulse_burst_board;
        lpse_pkg::t_cfg    regs;
        lpse_pkg::t_result expected_bytes[$];
        int unsigned       mismatches;
        int unsigned       components;
        int unsigned       words;
        int unsigned       status_seen[4];

        function new();
            regs                 = '0;
            regs.strip_type      = lpse_pkg::STRIP_LONG;
            regs.colour_order    = lpse_pkg::ORD_GRB;
            regs.colours_per_led = 3'd3;
            mismatches           = 0;
            components           = 0;
            words                = 0;
            status_seen          = '{0, 0, 0, 0};
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Red, green and blue go through the color order; the remaining slots keep their place.
        function logic [2:0] remap(logic [2:0] slot);
            logic [1:0] lane [3];
            if (slot > 3'd2) begin
                return slot;
            end
            case (regs.colour_order)
                lpse_pkg::ORD_GRB: lane = '{2'd1, 2'd0, 2'd2};
                lpse_pkg::ORD_GBR: lane = '{2'd2, 2'd0, 2'd1};
                lpse_pkg::ORD_RGB: lane = '{2'd0, 2'd1, 2'd2};
                lpse_pkg::ORD_RBG: lane = '{2'd0, 2'd2, 2'd1};
                lpse_pkg::ORD_BGR: lane = '{2'd2, 2'd1, 2'd0};
                lpse_pkg::ORD_BRG: lane = '{2'd1, 2'd2, 2'd0};
                default:           lane = '{2'd0, 2'd1, 2'd2};
            endcase
            return {1'b0, lane[slot]};
        endfunction

        function void note_component(lpse_pkg::t_item_in it);
            logic [2:0]        mapped;
            logic [31:0]       pulses;
            int unsigned       span;
            int unsigned       base_addr;
            int                b;
            int unsigned       k;
            lpse_pkg::t_result w;
            components++;
            w      = '0;
            w.last = 1'b1;
            if (it.led_index >= regs.led_count) begin
                w.status = lpse_pkg::ST_LED_OFF;
                expected_bytes.push_back(w);
                return;
            end
            if (it.colour_slot >= regs.colours_per_led) begin
                w.status = lpse_pkg::ST_BAD_SLOT;
                expected_bytes.push_back(w);
                return;
            end
            mapped    = remap(it.colour_slot);
            span      = (regs.strip_type == lpse_pkg::STRIP_THREE) ? 3 : 4;
            base_addr = 32'(regs.base_offset) + (32'(it.led_index) * 32'(regs.colours_per_led)
                        + 32'(mapped)) * span;
            if (base_addr + span - 1 > 32'hFFFF) begin
                w.status = lpse_pkg::ST_ADDR_OVF;
                expected_bytes.push_back(w);
                return;
            end
            // Three-byte strips send each LED bit as 1,b,0; the others as one nibble per bit.
            pulses = '0;
            for (b = 7; b >= 0; b--) begin
                if (span == 3) begin
                    pulses = {pulses[28:0], 1'b1, it.level[b], 1'b0};
                end else if (!it.level[b]) begin
                    pulses = {pulses[27:0], 4'b1000};
                end else if (regs.strip_type == lpse_pkg::STRIP_SHORT) begin
                    pulses = {pulses[27:0], 4'b1100};
                end else begin
                    pulses = {pulses[27:0], 4'b1110};
                end
            end
            for (k = 0; k < span; k++) begin
                w.byte_address = 16'(base_addr + k);
                w.pattern_byte = pulses[8 * (span - 1 - k) +: 8];
                w.last         = (k == span - 1);
                w.status       = lpse_pkg::ST_OK;
                expected_bytes.push_back(w);
            end
        endfunction

        task check_word(lpse_pkg::t_result got);
            lpse_pkg::t_result want;
            words++;
            if (expected_bytes.size() == 0) begin
                report($sformatf("word with nothing pending: address %h byte %h last %b status %0d",
                                 got.byte_address, got.pattern_byte, got.last, got.status));
                return;
            end
            want = expected_bytes.pop_front();
            status_seen[want.status]++;
            if (got.byte_address !== want.byte_address) begin
                report($sformatf("byte_address got %h want %h", got.byte_address,
                                 want.byte_address));
            end
            if (got.pattern_byte !== want.pattern_byte) begin
                report($sformatf("pattern_byte got %h want %h at address %h", got.pattern_byte,
                                 want.pattern_byte, want.byte_address));
            end
            if (got.last !== want.last) begin
                report($sformatf("last got %b want %b at address %h", got.last, want.last,
                                 want.byte_address));
            end
            if (got.status !== want.status) begin
                report($sformatf("status got %0d want %0d", got.status, want.status));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    lpse_pkg::t_item_in i_item;
    logic               o_valid;
    lpse_pkg::t_result  o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    pulse_burst_board sb;
    int unsigned      stall_cycles = 0;
    int unsigned      settings_used = 0;
    // When set, the sender offers a new word on every cycle the block can take it.
    bit               steady = 1'b0;

    led_pixel_spi_pulse_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // Every output word is shown for exactly one cycle and cannot be held off, so it is taken
    // at the edge that ends that cycle. Values read right after the edge are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_word(o_result);
        end
    end

    // The watchdog restarts on any handshake: an accepted word, an output word or a
    // register write. A run that stops making progress ends here as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("Watchdog: %0d cycles without a handshake", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic lpse_pkg::t_item_in make_item(logic [15:0] led, logic [2:0] slot,
                                                     logic [7:0] level);
        lpse_pkg::t_item_in it;
        it.led_index   = led;
        it.colour_slot = slot;
        it.level       = level;
        return it;
    endfunction

    function automatic lpse_pkg::t_cfg make_cfg(logic [1:0] stype, logic [2:0] order,
                                                logic [2:0] colours, logic [15:0] count,
                                                logic [15:0] offset);
        lpse_pkg::t_cfg c;
        c.strip_type      = stype;
        c.colour_order    = order;
        c.colours_per_led = colours;
        c.led_count       = count;
        c.base_offset     = offset;
        return c;
    endfunction

    // Mostly words that address a real LED and a real slot, so that they reach the encoder;
    // the rest are arbitrary and mostly end in an error word.
    function automatic lpse_pkg::t_item_in random_component();
        lpse_pkg::t_item_in it;
        int unsigned        near_end;
        it.level = 8'($urandom);
        if ($urandom_range(99) < 80 && sb.regs.led_count != 0) begin
            near_end     = (sb.regs.led_count > 256) ? 255 : sb.regs.led_count - 1;
            it.led_index = $urandom_range(1) ? 16'($urandom_range(near_end))
                                             : 16'($urandom_range(sb.regs.led_count - 1));
            it.colour_slot = (sb.regs.colours_per_led == 0) ? 3'($urandom_range(7))
                             : 3'($urandom_range(sb.regs.colours_per_led - 1));
        end else begin
            it.led_index   = 16'($urandom);
            it.colour_slot = 3'($urandom);
        end
        return it;
    endfunction

    // One register write: a setup phase, then an access phase that ends in the write edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Every word produces at least one output word, so an empty queue means the pipeline has
    // delivered everything; the extra cycles catch any stray word that might still follow.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers feed the pipeline directly, so they only change with nothing in flight.
    task automatic apply_settings(input lpse_pkg::t_cfg c);
        wait_drained();
        write_reg(lpse_pkg::REG_STRIP_TYPE, 32'(c.strip_type));
        write_reg(lpse_pkg::REG_COLOUR_ORDER, 32'(c.colour_order));
        write_reg(lpse_pkg::REG_COLOURS, 32'(c.colours_per_led));
        write_reg(lpse_pkg::REG_LED_COUNT, 32'(c.led_count));
        write_reg(lpse_pkg::REG_BASE_OFFSET, 32'(c.base_offset));
        sb.regs = c;
        settings_used++;
    endtask

    // Offers one word and holds it until the block takes it. A random pause may come first;
    // when there is none, start simply stays high into the next word.
    task automatic send_component(input lpse_pkg::t_item_in it);
        while (!steady && $urandom_range(99) < 9) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sb.note_component(it);
    endtask

    initial begin
        lpse_pkg::t_cfg rc;
        int             phase;
        sb      = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the strip has no LEDs, so any word is off the end.
        send_component(make_item(16'd0, 3'd0, 8'h00));

        // Long-high strip, default order: level extremes, the last LED, one past it, and a
        // slot just beyond the color count.
        apply_settings(make_cfg(lpse_pkg::STRIP_LONG, lpse_pkg::ORD_GRB, 3'd3, 16'd4, 16'd0));
        send_component(make_item(16'd0, 3'd0, 8'h00));
        send_component(make_item(16'd0, 3'd1, 8'hFF));
        send_component(make_item(16'd0, 3'd2, 8'hA5));
        send_component(make_item(16'd3, 3'd2, 8'h5A));
        send_component(make_item(16'd4, 3'd0, 8'h11));
        send_component(make_item(16'd1, 3'd3, 8'h22));

        // Three-byte strip with seven colors and the largest strip: a high slot, an address
        // far past the buffer, the top slot, an ordinary remapped word and the LED past the end.
        apply_settings(make_cfg(lpse_pkg::STRIP_THREE, lpse_pkg::ORD_BRG, 3'd7, 16'hFFFF,
                                16'd0));
        send_component(make_item(16'd0, 3'd6, 8'hFF));
        send_component(make_item(16'hFFFE, 3'd0, 8'h3C));
        send_component(make_item(16'd2, 3'd7, 8'h81));
        send_component(make_item(16'd1, 3'd1, 8'h6C));
        send_component(make_item(16'hFFFF, 3'd0, 8'h00));

        // Short-high strip, unused order, one color: the last four bytes end exactly at the top
        // of the buffer; a second slot is rejected.
        apply_settings(make_cfg(lpse_pkg::STRIP_SHORT, ORD_SPARE_HI, 3'd1, 16'd100, 16'd65532));
        send_component(make_item(16'd0, 3'd0, 8'hC3));
        send_component(make_item(16'd0, 3'd1, 8'h00));

        // Unused strip type, one color: red remaps to blue, past the color count, and still
        // gets an address.
        apply_settings(make_cfg(STRIP_SPARE, lpse_pkg::ORD_BGR, 3'd1, 16'd10, 16'd0));
        send_component(make_item(16'd2, 3'd0, 8'h96));

        // No colors at all: every slot is a bad slot.
        apply_settings(make_cfg(lpse_pkg::STRIP_LONG, lpse_pkg::ORD_RBG, 3'd0, 16'd10, 16'd0));
        send_component(make_item(16'd0, 3'd0, 8'h01));

        // Largest offset with the other unused order: the very first byte overflows.
        apply_settings(make_cfg(lpse_pkg::STRIP_SHORT, ORD_SPARE_LO, 3'd2, 16'hFFFF, 16'hFFFF));
        send_component(make_item(16'd0, 3'd1, 8'h7E));

        // Three-byte strip whose burst ends exactly at the top of the buffer.
        apply_settings(make_cfg(lpse_pkg::STRIP_THREE, lpse_pkg::ORD_RGB, 3'd5, 16'd5,
                                16'd65533));
        send_component(make_item(16'd0, 3'd0, 8'h81));

        // Random phases, each with its own register settings. The first uses the largest
        // strip, the last a single LED near the top of the buffer, and one phase runs with no
        // pauses at all so that the queue in front of the serializer fills up.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            rc = make_cfg(2'($urandom_range(3)), 3'($urandom_range(7)),
                          ($urandom_range(7) == 0) ? 3'd0 : 3'($urandom_range(7, 1)),
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1)),
                          ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 60000))
                                                   : 16'($urandom_range(1023)));
            if (phase == 0) begin
                rc.led_count       = 16'hFFFF;
                rc.colours_per_led = 3'd7;
                rc.base_offset     = 16'd0;
            end
            if (phase == RANDOM_PHASES - 1) begin
                rc.led_count   = 16'd1;
                rc.base_offset = 16'hFFF0;
            end
            apply_settings(rc);
            steady = (phase == 3);
            repeat (PHASE_ITEMS) send_component(random_component());
        end

        wait_drained();
        $display("Run covered %0d color words and %0d output words over %0d register settings.",
                 sb.components, sb.words, settings_used);
        $display("Output words by status: ok %0d, LED off end %0d, bad slot %0d, overflow %0d.",
                 sb.status_seen[lpse_pkg::ST_OK], sb.status_seen[lpse_pkg::ST_LED_OFF],
                 sb.status_seen[lpse_pkg::ST_BAD_SLOT], sb.status_seen[lpse_pkg::ST_ADDR_OVF]);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lpse_pkg.sv
hw/rtl/lpse_cfg.sv
hw/rtl/lpse_index.sv
hw/rtl/lpse_addr.sv
hw/rtl/lpse_ser.sv
hw/rtl/led_pixel_spi_pulse_encoder.sv
test/tb_led_pixel_spi_pulse_encoder.sv
